// ----- hdl/hprg_pkg.sv -----
// ----------------------------------------------------------------------------
// hprg_pkg - shared types and constants of the hash pool random generator
// Round constants of the compression function and the beat payload types.
// ----------------------------------------------------------------------------
`default_nettype none
package hprg_pkg;

   typedef struct packed {
      logic [63:0] entropy_word_3;
      logic [63:0] entropy_word_2;
      logic [63:0] entropy_word_1;
      logic [63:0] entropy_word_0;
      logic [5:0]  bytes_wanted;
   } req_type;

   typedef struct packed {
      logic [63:0] random_word_3;
      logic [63:0] random_word_2;
      logic [63:0] random_word_1;
      logic [63:0] random_word_0;
      logic [5:0]  valid_bytes;
   } rsp_type;

   localparam logic [5:0] DIGEST_BYTES = 6'd32;

   localparam logic [255:0] IV = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   // byte-swap a 64-bit word: little-endian packing to message byte order
   function automatic logic [63:0] bswap64(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 8; i++) r[8*i +: 8] = v[8*(7-i) +: 8];
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/hprg_if.sv -----
// ----------------------------------------------------------------------------
// hprg_req_if / hprg_rsp_if - valid/ready channels of the generator
// One beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
`default_nettype none
interface hprg_req_if;
   logic              valid;
   logic              ready;
   hprg_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface hprg_rsp_if;
   logic              valid;
   logic              ready;
   hprg_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- hdl/hash_pool_random_generator_unit.sv -----
// ----------------------------------------------------------------------------
// hash_pool_random_generator_unit - hash pool random generator
// Stirs fresh entropy into a 256-bit pool and emits one 32-byte digest.
//
// req channel: four 64-bit entropy words and a byte count 0 to 63, capped at 32.
// rsp channel: four 64-bit random words, bytes past valid_bytes zeroed.
// Each request bumps a 64-bit counter, replaces the pool with the hash of
// pool, entropy and counter (two blocks), then hashes pool and counter
// (one block) for the output. One compression engine at one round a
// cycle runs three times per request, once for each block. A zero count
// gives an all-zero response on the next cycle and leaves the state alone.
// req_ready is high only when idle; the response register holds until
// rsp_ready and the next request is taken only after it leaves.
// Reset clears pool and counter and drops rsp_valid.
// ----------------------------------------------------------------------------
`default_nettype none
module hash_pool_random_generator_unit (
   input  wire logic clock,
   input  wire logic reset,
   hprg_req_if.sink  req,
   hprg_rsp_if.source rsp
);
   localparam logic [2:0] ST_IDLE = 3'd0, ST_B1 = 3'd1, ST_B2 = 3'd2, ST_B3 = 3'd3,
                          ST_OUT = 3'd4, ST_B4 = 3'd5;

   logic [2:0]   state_ff, state_in;
   logic [255:0] pool_ff, pool_in, chain_ff, chain_in;
   logic [63:0]  cnt_ff, cnt_in;
   logic [255:0] ent_ff, ent_in;
   logic [5:0]   want_ff, want_in;
   hprg_pkg::rsp_type rsp_ff, rsp_in;
   logic         start;
   logic [511:0] block;
   logic         done;
   logic [255:0] digest;
   logic [255:0] le_dig, masked;
   logic [63:0]  cnt_be;
   logic [5:0]   wsat;

   hprg_core u_core (.clock(clock), .reset(reset), .start(start), .chain(chain_in),
                     .block(block), .done(done), .digest(digest));

   assign cnt_be = hprg_pkg::bswap64(cnt_ff);
   assign wsat = (req.payload.bytes_wanted > hprg_pkg::DIGEST_BYTES)
                 ? hprg_pkg::DIGEST_BYTES : req.payload.bytes_wanted;

   always_comb begin
      // digest is big-endian byte stream; repack into little-endian words
      for (int i = 0; i < 32; i++) le_dig[8*i +: 8] = digest[255-8*i -: 8];
      for (int i = 0; i < 32; i++)
         masked[8*i +: 8] = (6'(i) < want_ff) ? le_dig[8*i +: 8] : 8'h00;
   end

   always_comb begin
      state_in = state_ff; pool_in = pool_ff; cnt_in = cnt_ff; chain_in = chain_ff;
      ent_in = ent_ff; want_in = want_ff; rsp_in = rsp_ff;
      start = 1'b0;
      block = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               if (req.payload.bytes_wanted == 6'd0) begin
                  rsp_in = '0;
                  state_in = ST_OUT;
               end else begin
                  ent_in = {req.payload.entropy_word_3, req.payload.entropy_word_2,
                            req.payload.entropy_word_1, req.payload.entropy_word_0};
                  want_in = wsat;
                  cnt_in = cnt_ff + 64'd1;
                  chain_in = hprg_pkg::IV;
                  state_in = ST_B1;
               end
            end
         end
         ST_B1: begin
            // pool and entropy, message bytes 0..63
            for (int i = 0; i < 4; i++) begin
               block[511-64*i -: 64] = hprg_pkg::bswap64(pool_ff[64*i +: 64]);
               block[255-64*i -: 64] = hprg_pkg::bswap64(ent_ff[64*i +: 64]);
            end
            start = 1'b1;
            state_in = ST_B2;
         end
         ST_B2: begin
            if (done) begin
               chain_in = digest;
               block = {cnt_be, 8'h80, 376'd0, 64'd576};
               start = 1'b1;
               state_in = ST_B3;
            end
         end
         ST_B3: begin
            if (done) begin
               pool_in = le_dig;
               chain_in = hprg_pkg::IV;
               block = {digest, cnt_be, 8'h80, 120'd0, 64'd320};
               start = 1'b1;
               state_in = ST_B4;
            end
         end
         ST_B4: begin
            if (done) begin
               rsp_in = {masked[255:192], masked[191:128], masked[127:64], masked[63:0],
                         want_ff};
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      chain_ff <= chain_in;
      ent_ff <= ent_in;
      want_ff <= want_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         pool_ff <= '0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         pool_ff <= pool_in;
         cnt_ff <= cnt_in;
      end
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.payload = rsp_ff;
endmodule
`default_nettype wire

// ----- hdl/hprg_core.sv -----
// ----------------------------------------------------------------------------
// hprg_core - one-round-per-cycle compression engine
// Runs 64 rounds over a 512-bit block with a rolling 16-word schedule and
// adds the chaining value at the end.
// ----------------------------------------------------------------------------
`default_nettype none
module hprg_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [255:0] chain,
   input  wire logic [511:0] block,
   output logic              done,
   output logic [255:0]      digest
);
   logic [31:0]  w_ff [16];
   logic [31:0]  w_in [16];
   logic [31:0]  s_ff [8];
   logic [31:0]  s_in [8];
   logic [255:0] chain_ff, chain_in;
   logic [5:0]   rnd_ff, rnd_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [31:0]  t1, t2, s0, s1, wn;

   always_comb begin
      t1 = s_ff[7] + ({s_ff[4][5:0], s_ff[4][31:6]} ^ {s_ff[4][10:0], s_ff[4][31:11]}
           ^ {s_ff[4][24:0], s_ff[4][31:25]}) + ((s_ff[4] & s_ff[5]) ^ (~s_ff[4] & s_ff[6]))
           + hprg_pkg::round_k(rnd_ff) + w_ff[0];
      t2 = ({s_ff[0][1:0], s_ff[0][31:2]} ^ {s_ff[0][12:0], s_ff[0][31:13]}
           ^ {s_ff[0][21:0], s_ff[0][31:22]})
           + ((s_ff[0] & s_ff[1]) ^ (s_ff[0] & s_ff[2]) ^ (s_ff[1] & s_ff[2]));
      s0 = {w_ff[1][6:0], w_ff[1][31:7]} ^ {w_ff[1][17:0], w_ff[1][31:18]} ^ (w_ff[1] >> 3);
      s1 = {w_ff[14][16:0], w_ff[14][31:17]} ^ {w_ff[14][18:0], w_ff[14][31:19]}
           ^ (w_ff[14] >> 10);
      wn = w_ff[0] + s0 + w_ff[9] + s1;
      w_in = w_ff; s_in = s_ff; chain_in = chain_ff;
      rnd_in = rnd_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         for (int i = 0; i < 16; i++) w_in[i] = block[511-32*i -: 32];
         for (int i = 0; i < 8; i++) s_in[i] = chain[255-32*i -: 32];
         chain_in = chain;
         rnd_in = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
         w_in[15] = wn;
         s_in[7] = s_ff[6]; s_in[6] = s_ff[5]; s_in[5] = s_ff[4];
         s_in[4] = s_ff[3] + t1;
         s_in[3] = s_ff[2]; s_in[2] = s_ff[1]; s_in[1] = s_ff[0];
         s_in[0] = t1 + t2;
         rnd_in = rnd_ff + 6'd1;
         if (rnd_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      s_ff <= s_in;
      chain_ff <= chain_in;
      rnd_ff <= rnd_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++)
         digest[255-32*i -: 32] = chain_ff[255-32*i -: 32] + s_ff[i];
   end
   assign done = done_ff;
endmodule
`default_nettype wire

// ----- bench/tb_hash_pool_random_generator_unit.sv -----
// ----------------------------------------------------------------------------
// tb_hash_pool_random_generator_unit - regression bench of the hash pool generator
// Drives entropy beats with random gaps, stalls the response side at random,
// and checks every response against a SHA-256 pool model kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_hash_pool_random_generator_unit;

   localparam int WATCHDOG_LIMIT = 20000;

   class pool_scoreboard;
      logic [63:0] pool [4];
      logic [63:0] counter;
      hprg_pkg::rsp_type pending [$];
      int          mismatches;

      function new();
         for (int i = 0; i < 4; i++) pool[i] = '0;
         counter    = '0;
         mismatches = 0;
      endfunction

      static function logic [31:0] rotr(logic [31:0] x, int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      static function logic [31:0] kconst(int i);
         logic [31:0] tbl [64];
         tbl = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
         return tbl[i];
      endfunction

      // message bytes in, digest bytes out; len at most 119
      static function void sha256(input logic [7:0] msg [128], input int len,
                                  output logic [7:0] dig [32]);
         logic [7:0]  buf8 [128];
         logic [31:0] h [8];
         logic [31:0] w [64];
         logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
         logic [63:0] bits;
         int          blocks;
         h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
               32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
         for (int i = 0; i < 128; i++) buf8[i] = (i < len) ? msg[i] : 8'h00;
         buf8[len] = 8'h80;
         blocks = (len + 72) / 64;
         bits   = 64'(len * 8);
         for (int i = 0; i < 8; i++) buf8[blocks * 64 - 1 - i] = bits[8*i +: 8];
         for (int blk = 0; blk < blocks; blk++) begin
            for (int i = 0; i < 16; i++)
               w[i] = {buf8[blk*64+4*i], buf8[blk*64+4*i+1],
                       buf8[blk*64+4*i+2], buf8[blk*64+4*i+3]};
            for (int i = 16; i < 64; i++) begin
               s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
               s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
               w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            a = h[0]; b = h[1]; c = h[2]; d = h[3];
            e = h[4]; f = h[5]; g = h[6]; hh = h[7];
            for (int i = 0; i < 64; i++) begin
               t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
                    ((e & f) ^ (~e & g)) + kconst(i) + w[i];
               t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
                    ((a & b) ^ (a & c) ^ (b & c));
               hh = g; g = f; f = e; e = d + t1;
               d = c; c = b; b = a; a = t1 + t2;
            end
            h[0] += a; h[1] += b; h[2] += c; h[3] += d;
            h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
         end
         for (int i = 0; i < 8; i++) begin
            dig[4*i]   = h[i][31:24];
            dig[4*i+1] = h[i][23:16];
            dig[4*i+2] = h[i][15:8];
            dig[4*i+3] = h[i][7:0];
         end
      endfunction

      function void note_request(hprg_pkg::req_type r);
         logic [7:0]  msg [128];
         logic [7:0]  dig [32];
         logic [63:0] ent [4];
         logic [63:0] outw [4];
         hprg_pkg::rsp_type x;
         int          wanted;
         x      = '0;
         wanted = int'(r.bytes_wanted);
         if (wanted != 0) begin
            if (wanted > 32) wanted = 32;
            counter = counter + 1;
            ent = '{r.entropy_word_0, r.entropy_word_1, r.entropy_word_2, r.entropy_word_3};
            for (int i = 0; i < 128; i++) msg[i] = 8'h00;
            for (int k = 0; k < 4; k++)
               for (int i = 0; i < 8; i++) begin
                  msg[8*k+i]    = pool[k][8*i +: 8];
                  msg[32+8*k+i] = ent[k][8*i +: 8];
               end
            for (int i = 0; i < 8; i++) msg[64+i] = counter[8*i +: 8];
            sha256(msg, 72, dig);
            for (int k = 0; k < 4; k++)
               for (int i = 0; i < 8; i++) pool[k][8*i +: 8] = dig[8*k+i];
            for (int i = 0; i < 32; i++) msg[i] = dig[i];
            for (int i = 0; i < 8; i++) msg[32+i] = counter[8*i +: 8];
            sha256(msg, 40, dig);
            for (int i = wanted; i < 32; i++) dig[i] = 8'h00;
            for (int k = 0; k < 4; k++)
               for (int i = 0; i < 8; i++) outw[k][8*i +: 8] = dig[8*k+i];
            x.random_word_0 = outw[0];
            x.random_word_1 = outw[1];
            x.random_word_2 = outw[2];
            x.random_word_3 = outw[3];
            x.valid_bytes   = 6'(wanted);
         end
         pending.push_back(x);
      endfunction

      function void check_response(hprg_pkg::rsp_type got);
         hprg_pkg::rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %h", got);
            return;
         end
         want = pending.pop_front();
         if (got.random_word_0 !== want.random_word_0 ||
             got.random_word_1 !== want.random_word_1 ||
             got.random_word_2 !== want.random_word_2 ||
             got.random_word_3 !== want.random_word_3 ||
             got.valid_bytes !== want.valid_bytes) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response mismatch: expected %h %h %h %h / %0d",
                        want.random_word_3, want.random_word_2, want.random_word_1,
                        want.random_word_0, want.valid_bytes);
               $display("                   actual   %h %h %h %h / %0d",
                        got.random_word_3, got.random_word_2, got.random_word_1,
                        got.random_word_0, got.valid_bytes);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   idle_cycles;
   bit   stim_done;

   hprg_req_if req ();
   hprg_rsp_if rsp ();

   hash_pool_random_generator_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   pool_scoreboard board = new();

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic int gap_length();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(20, 300);
      return $urandom_range(0, 4);
   endfunction

   function automatic logic [63:0] random_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_request(hprg_pkg::req_type r);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req.valid   <= 1'b0;
         req.payload <= {random_word(), random_word(), random_word(), random_word(),
                         6'($urandom)};
         repeat (gap) @(negedge clock);
      end
      req.payload <= r;
      req.valid   <= 1'b1;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_entropy(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                               logic [63:0] w3, logic [5:0] count);
      hprg_pkg::req_type r;
      r.entropy_word_0 = w0;
      r.entropy_word_1 = w1;
      r.entropy_word_2 = w2;
      r.entropy_word_3 = w3;
      r.bytes_wanted   = count;
      send_request(r);
   endtask

   // input and output beats, plus the stall watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req.valid && req.ready) board.note_request(req.payload);
         if (rsp.valid && rsp.ready) board.check_response(rsp.payload);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
             (stim_done && board.pending.size() == 0))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("hash_pool_random_generator_unit regression: fail");
            $finish;
         end
      end
   end

   // response side stalls
   initial begin
      int n;
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         n = gap_length();
         if (n > 0) begin
            rsp.ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp.ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(negedge clock);
      end
   end

   initial begin
      stim_done   = 1'b0;
      reset       = 1'b1;
      req.valid   = 1'b0;
      req.payload = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, zero count, oversize counts, single bits
      send_entropy('0, '0, '0, '0, 6'd1);
      send_entropy('1, '1, '1, '1, 6'd32);
      send_entropy('0, '0, '0, '0, 6'd0);
      send_entropy('1, '0, '1, '0, 6'd33);
      send_entropy('0, '1, '0, '1, 6'd63);
      send_entropy(64'h0123456789abcdef, 64'hfedcba9876543210, 64'h1, 64'h8000000000000000,
                   6'd31);
      send_entropy('1, '1, '1, '1, 6'd0);
      for (int i = 0; i < 6; i++)
         send_entropy({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, 6'd1 << i);
      for (int i = 1; i <= 8; i++)
         send_entropy('0, '0, '0, '0, 6'(4 * i - 1));

      // random: mostly legal counts, some zero and oversize
      for (int i = 0; i < 600; i++) begin
         logic [5:0] cnt;
         case ($urandom_range(0, 19))
            0:       cnt = 6'd0;
            1:       cnt = 6'($urandom_range(33, 63));
            2:       cnt = 6'd32;
            default: cnt = 6'($urandom_range(1, 32));
         endcase
         send_entropy(random_word(), random_word(), random_word(), random_word(), cnt);
      end
      req.valid <= 1'b0;

      stim_done = 1'b1;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("hash_pool_random_generator_unit regression: pass");
      else
         $display("hash_pool_random_generator_unit regression: fail");
      $finish;
   end

endmodule
`default_nettype wire
